[sv/serial_eeprom_loader_protocol_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the serial image loader
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SERIAL_EEPROM_LOADER_PROTOCOL_ASSERT_SVH
`define SERIAL_EEPROM_LOADER_PROTOCOL_ASSERT_SVH
`ifndef SYNTHESIS
// check that prop holds at every rising clock edge outside reset
`define SEL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that an implication holds outside reset
`define SEL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SEL_ASSERT(lbl, prop, msg)
`define SEL_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[sv/sel_pkg.sv]
// ----------------------------------------------------------------------------
// sel_pkg
// Shared types, control codes and the banner for the image loader.
// ----------------------------------------------------------------------------
`default_nettype none
package sel_pkg;
	localparam logic [7:0] C_SOH = 8'h01;
	localparam logic [7:0] C_STX = 8'h02;
	localparam logic [7:0] C_ETX = 8'h03;
	localparam logic [7:0] C_EOT = 8'h04;
	localparam logic [7:0] C_ACK = 8'h06;
	localparam logic [7:0] C_NAK = 8'h15;
	localparam logic [7:0] C_SYN = 8'h16;
	localparam logic [7:0] C_ETB = 8'h17;
	localparam logic [7:0] C_US  = 8'h1f;

	localparam logic [16:0] MAX_IMAGE_BYTES = 17'd32768;
	localparam int unsigned MEM_DEPTH = 32768;
	localparam logic [12:0] VEC_PAGE = 13'h1fff;

	localparam logic CFG_WRITE_CMD = 1'b0;
	localparam logic CFG_READ_CMD  = 1'b1;

	localparam logic [2:0] K_LIT    = 3'd0;
	localparam logic [2:0] K_BANNER = 3'd1;
	localparam logic [2:0] K_VEC    = 3'd2;
	localparam logic [2:0] K_WR     = 3'd3;
	localparam logic [2:0] K_RD     = 3'd4;

	localparam logic [4:0] BANNER_LEN = 5'd20;

	typedef struct packed {
		logic [2:0]      kind;
		logic [2:0]      cnt;
		logic [3:0][7:0] lit;
		logic [14:0]     addr;
		logic [7:0]      data;
		logic [31:0]     vec;
		logic            tail;
	} cmd_t;

	function automatic logic [7:0] banner_byte(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0: r = "E";  5'd1: r = "E";  5'd2: r = "P";  5'd3: r = "R";
			5'd4: r = "O";  5'd5: r = "M";  5'd6: r = " ";  5'd7: r = "P";
			5'd8: r = "r";  5'd9: r = "o";  5'd10: r = "g"; 5'd11: r = "r";
			5'd12: r = "a"; 5'd13: r = "m"; 5'd14: r = "m"; 5'd15: r = "e";
			5'd16: r = "r"; 5'd17: r = " "; 5'd18: r = "v"; 5'd19: r = "2";
			default: r = C_SYN;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

[sv/sel_in_if.sv]
// ----------------------------------------------------------------------------
// sel_in_if
// Input channel: received byte or free transmit slot.
// ----------------------------------------------------------------------------
`default_nettype none
interface sel_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	modport source (output valid, op, rx_byte, input ready);
	modport sink (input valid, op, rx_byte, output ready);
endinterface
`default_nettype wire

[sv/sel_out_if.sv]
// ----------------------------------------------------------------------------
// sel_out_if
// Output channel: bytes to transmit.
// ----------------------------------------------------------------------------
`default_nettype none
interface sel_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_of_run;
	modport source (output valid, tx_byte, last_of_run, input ready);
	modport sink (input valid, tx_byte, last_of_run, output ready);
endinterface
`default_nettype wire

[sv/sel_front.sv]
// ----------------------------------------------------------------------------
// sel_front
// Protocol parser: tracks the session phase and turns each item that produces output into a command.
// ----------------------------------------------------------------------------
`default_nettype none
module sel_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc_go,
	input  wire logic              op,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              cfg_we,
	input  wire logic              cfg_idx,
	input  wire logic [7:0]        cfg_wdata,
	output logic                   enq,
	output sel_pkg::cmd_t          cmd
);
	localparam logic [3:0] PH_WAIT_SYN = 4'd0;
	localparam logic [3:0] PH_WAIT_SOH = 4'd1;
	localparam logic [3:0] PH_GET_CMD  = 4'd2;
	localparam logic [3:0] PH_F_START  = 4'd3;
	localparam logic [3:0] PH_F_LEN    = 4'd4;
	localparam logic [3:0] PH_F_RESET  = 4'd5;
	localparam logic [3:0] PH_F_IRQ    = 4'd6;
	localparam logic [3:0] PH_WAIT_STX = 4'd7;
	localparam logic [3:0] PH_WR_DATA  = 4'd8;
	localparam logic [3:0] PH_WAIT_ETX = 4'd9;
	localparam logic [3:0] PH_RD_DATA  = 4'd10;

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  wcode_q, rcode_q, cmdb_q, cmdb_d;
	logic [15:0] acc_q, acc_d, start_q, start_d, count_q, count_d;
	logic [15:0] rvec_q, rvec_d, cursor_q, cursor_d, cursor_inc;
	logic [16:0] end_addr;
	logic        hex_ok;
	logic [3:0]  hex_v;
	logic [7:0]  lc;
	logic [15:0] hex_acc, dec_acc;

	assign end_addr   = {1'b0, start_q} + {1'b0, count_q};
	assign cursor_inc = cursor_q + 16'd1;
	assign lc         = rx_byte | 8'h20;
	assign hex_acc    = {acc_q[11:0], hex_v};
	assign dec_acc    = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {8'h00, rx_byte} - 16'h0030;

	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		if (rx_byte >= "0" && rx_byte <= "9") begin
			hex_v = rx_byte[3:0];
		end else if (lc >= "a" && lc <= "f") begin
			hex_v = 4'(lc - "a" + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		cmdb_d   = cmdb_q;
		acc_d    = acc_q;
		start_d  = start_q;
		count_d  = count_q;
		rvec_d   = rvec_q;
		cursor_d = cursor_q;
		enq      = 1'b0;
		cmd      = '0;
		cmd.kind = sel_pkg::K_LIT;
		if (op) begin
			if (phase_q == PH_RD_DATA) begin
				enq      = acc_go;
				cmd.kind = sel_pkg::K_RD;
				cmd.addr = cursor_q[14:0];
				cmd.tail = ({1'b0, cursor_inc} == end_addr);
				cursor_d = cursor_inc;
				if (cmd.tail) begin
					phase_d = PH_WAIT_SYN;
				end
			end
		end else begin
			unique case (phase_q)
				PH_WAIT_SYN: begin
					if (rx_byte == sel_pkg::C_SYN) begin
						enq      = acc_go;
						cmd.kind = sel_pkg::K_BANNER;
						phase_d  = PH_WAIT_SOH;
					end
				end
				PH_WAIT_SOH: begin
					if (rx_byte == sel_pkg::C_SOH) begin
						phase_d = PH_GET_CMD;
					end
				end
				PH_GET_CMD: begin
					cmdb_d  = rx_byte;
					acc_d   = '0;
					phase_d = PH_F_START;
				end
				PH_F_START: begin
					if (rx_byte == sel_pkg::C_US) begin
						start_d = acc_q;
						acc_d   = '0;
						phase_d = PH_F_LEN;
					end else if (hex_ok) begin
						acc_d = hex_acc;
					end
				end
				PH_F_LEN: begin
					if (rx_byte == sel_pkg::C_US) begin
						count_d = acc_q;
						acc_d   = '0;
						phase_d = PH_F_RESET;
					end else begin
						acc_d = dec_acc;
					end
				end
				PH_F_RESET: begin
					if (rx_byte == sel_pkg::C_US) begin
						rvec_d  = acc_q;
						acc_d   = '0;
						phase_d = PH_F_IRQ;
					end else if (hex_ok) begin
						acc_d = hex_acc;
					end
				end
				PH_F_IRQ: begin
					if (rx_byte == sel_pkg::C_ETB) begin
						acc_d = '0;
						enq   = acc_go;
						if (end_addr > sel_pkg::MAX_IMAGE_BYTES) begin
							cmd.cnt    = 3'd2;
							cmd.lit[0] = sel_pkg::C_NAK;
							cmd.lit[1] = sel_pkg::C_EOT;
							phase_d    = PH_WAIT_SYN;
						end else begin
							cursor_d = start_q;
							if (cmdb_q == wcode_q) begin
								cmd.kind = sel_pkg::K_VEC;
								cmd.vec  = {acc_q, rvec_q};
								phase_d  = PH_WAIT_STX;
							end else if (cmdb_q == rcode_q) begin
								cmd.lit[0] = sel_pkg::C_ACK;
								cmd.lit[1] = sel_pkg::C_STX;
								if (count_q == 16'd0) begin
									cmd.cnt    = 3'd4;
									cmd.lit[2] = sel_pkg::C_ETX;
									cmd.lit[3] = sel_pkg::C_EOT;
									phase_d    = PH_WAIT_SYN;
								end else begin
									cmd.cnt = 3'd2;
									phase_d = PH_RD_DATA;
								end
							end else begin
								cmd.cnt    = 3'd2;
								cmd.lit[0] = sel_pkg::C_ACK;
								cmd.lit[1] = sel_pkg::C_EOT;
								phase_d    = PH_WAIT_SYN;
							end
						end
					end else if (hex_ok) begin
						acc_d = hex_acc;
					end
				end
				PH_WAIT_STX: begin
					if (rx_byte == sel_pkg::C_STX) begin
						phase_d = ({1'b0, cursor_q} == end_addr) ? PH_WAIT_ETX : PH_WR_DATA;
					end
				end
				PH_WR_DATA: begin
					enq      = acc_go;
					cmd.kind = sel_pkg::K_WR;
					cmd.addr = cursor_q[14:0];
					cmd.data = rx_byte;
					cursor_d = cursor_inc;
					if ({1'b0, cursor_inc} == end_addr) begin
						phase_d = PH_WAIT_ETX;
					end
				end
				PH_WAIT_ETX: begin
					if (rx_byte == sel_pkg::C_ETX) begin
						enq        = acc_go;
						cmd.cnt    = 3'd1;
						cmd.lit[0] = sel_pkg::C_EOT;
						phase_d    = PH_WAIT_SYN;
					end
				end
				PH_RD_DATA: begin
				end
				default: begin
					phase_d = PH_WAIT_SYN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_SYN;
			cmdb_q   <= '0;
			acc_q    <= '0;
			start_q  <= '0;
			count_q  <= '0;
			rvec_q   <= '0;
			cursor_q <= '0;
			wcode_q  <= 8'd1;
			rcode_q  <= 8'd2;
		end else begin
			if (acc_go) begin
				phase_q  <= phase_d;
				cmdb_q   <= cmdb_d;
				acc_q    <= acc_d;
				start_q  <= start_d;
				count_q  <= count_d;
				rvec_q   <= rvec_d;
				cursor_q <= cursor_d;
			end
			if (cfg_we && cfg_idx == sel_pkg::CFG_WRITE_CMD) begin
				wcode_q <= cfg_wdata;
			end
			if (cfg_we && cfg_idx == sel_pkg::CFG_READ_CMD) begin
				rcode_q <= cfg_wdata;
			end
		end
	end
endmodule
`default_nettype wire

[sv/sel_queue.sv]
// ----------------------------------------------------------------------------
// sel_queue
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_eeprom_loader_protocol_assert.svh"
module sel_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sel_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output logic               full,
	output logic               nonempty,
	output sel_pkg::cmd_t      head
);
	sel_pkg::cmd_t slot_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] count_q;

	assign full     = (count_q == 3'd4);
	assign nonempty = (count_q != 3'd0);
	assign head     = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			count_q <= count_q + {2'b00, push} - {2'b00, pop};
		end
	end

	`SEL_ASSERT(a_count_bound, count_q <= 3'd4, "queue count beyond depth")
	`SEL_ASSERT_IMP(a_no_underflow, pop, count_q != 3'd0, "pop from empty queue")
	`SEL_ASSERT_IMP(a_no_overflow, push && !pop, !full, "push into full queue")
endmodule
`default_nettype wire

[sv/sel_back.sv]
// ----------------------------------------------------------------------------
// sel_back
// Output sequencer: expands commands into bytes and owns the image memory.
// ----------------------------------------------------------------------------
`default_nettype none
module sel_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire sel_pkg::cmd_t head,
	output logic               pop,
	sel_out_if.source          tx
);
	logic [7:0] mem [sel_pkg::MEM_DEPTH];

	sel_pkg::cmd_t cur_q;
	logic          busy_q;
	logic [4:0]    idx_q;
	logic [7:0]    rdata_q;
	logic          ov_q, ol_q;
	logic [7:0]    ob_q;

	logic          ld, step_go, emit, fin, done, we;
	logic [7:0]    byte_s, wdata;
	logic [14:0]   waddr;

	assign ld      = !ov_q || tx.ready;
	assign step_go = busy_q && ld;
	assign done    = step_go && fin;
	assign pop     = head_valid && (!busy_q || done);

	always_comb begin
		emit   = 1'b1;
		fin    = 1'b1;
		byte_s = '0;
		we     = 1'b0;
		waddr  = cur_q.addr;
		wdata  = cur_q.data;
		case (cur_q.kind)
			sel_pkg::K_LIT: begin
				byte_s = cur_q.lit[idx_q[1:0]];
				fin    = ({2'b00, cur_q.cnt} == idx_q + 5'd1);
			end
			sel_pkg::K_BANNER: begin
				byte_s = sel_pkg::banner_byte(idx_q);
				fin    = (idx_q == sel_pkg::BANNER_LEN);
			end
			sel_pkg::K_VEC: begin
				// four vector bytes, then ACK with the last
				we     = 1'b1;
				waddr  = {sel_pkg::VEC_PAGE, idx_q[1:0]};
				wdata  = cur_q.vec[{idx_q[1:0], 3'b000} +: 8];
				fin    = (idx_q == 5'd3);
				emit   = fin;
				byte_s = sel_pkg::C_ACK;
			end
			sel_pkg::K_WR: begin
				we     = 1'b1;
				byte_s = cur_q.data;
			end
			sel_pkg::K_RD: begin
				fin = !cur_q.tail || (idx_q == 5'd2);
				case (idx_q[1:0])
					2'd0:    byte_s = rdata_q;
					2'd1:    byte_s = sel_pkg::C_ETX;
					default: byte_s = sel_pkg::C_EOT;
				endcase
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (step_go && we) begin
			mem[waddr] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[head.addr];
		end
		if (pop) begin
			cur_q <= head;
		end
		if (ld) begin
			ob_q <= byte_s;
			ol_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (step_go) begin
				idx_q <= idx_q + 5'd1;
			end
			if (ld) begin
				ov_q <= step_go && emit;
			end
		end
	end

	assign tx.valid       = ov_q;
	assign tx.tx_byte     = ob_q;
	assign tx.last_of_run = ol_q;
endmodule
`default_nettype wire

[sv/serial_eeprom_loader_protocol.sv]
// ----------------------------------------------------------------------------
// serial_eeprom_loader_protocol
// Serial byte-stream image loader with a 32 KiB on-chip image memory.
// ----------------------------------------------------------------------------
// Each input item is parsed in the cycle it is accepted and, if it produces
// output, leaves one command in a four-entry queue. The sequencer pops it into
// its current-command register when free and registers the first result byte
// in the output register. From then on it sends one byte per cycle while the
// receiver is ready, with no gap between commands: an item's result bytes go
// out back to back (21 for the SYN banner), and a header accepted for a write
// stores its four vector bytes, one per cycle while the output is not stalled,
// and sends ACK with the last. Input is taken one item per cycle while the
// queue has room; a stalled output fills the queue and then holds off the input.
`default_nettype none
module serial_eeprom_loader_protocol (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sel_in_if.sink          rx_item,
	sel_out_if.source       tx_item,
	input  wire logic       cfg_we,
	input  wire logic       cfg_idx,
	input  wire logic [7:0] cfg_wdata
);
	logic          acc_go, enq, full, nonempty, pop;
	sel_pkg::cmd_t cmd, head;

	assign rx_item.ready = !full;
	assign acc_go        = rx_item.valid && !full;

	sel_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_go    (acc_go),
		.op        (rx_item.op),
		.rx_byte   (rx_item.rx_byte),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.enq       (enq),
		.cmd       (cmd)
	);

	sel_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (enq),
		.push_cmd (cmd),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	sel_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (nonempty),
		.head       (head),
		.pop        (pop),
		.tx         (tx_item)
	);
endmodule
`default_nettype wire

[dv/tb_serial_eeprom_loader_protocol.sv]
// ----------------------------------------------------------------------------
// tb_serial_eeprom_loader_protocol
// Self-checking bench for the serial image loader. Whole load and dump
// sessions go in on the input channel and every output byte is checked
// against an in-bench protocol model.
// ----------------------------------------------------------------------------
module tb_serial_eeprom_loader_protocol;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		P_SYN, P_SOH, P_CMD, P_START, P_LEN, P_RST, P_IRQ,
		P_STX, P_WDATA, P_ETX, P_RDATA
	} phase_e;

	typedef struct packed {
		logic [7:0] tx;
		logic       last;
	} tx_exp_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_SLOT = 1'b1;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_idx = sel_pkg::CFG_WRITE_CMD;
	logic [7:0] cfg_wdata = 0;

	sel_in_if rx_item();
	sel_out_if tx_item();

	serial_eeprom_loader_protocol dut (
		.clk(clk), .arst_n(arst_n), .rx_item(rx_item.sink), .tx_item(tx_item.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// model state
	phase_e     ph;
	logic [7:0] wr_code, rd_code, cmd_b;
	logic [15:0] acc, start_a, len, rvec, ivec, cur;
	logic [7:0] image [0:32767];
	logic       written [0:32767];

	tx_exp_t tx_expected[$];
	int  errors = 0;
	longint cycles = 0;
	bit  hold_off = 0;
	int  long_stall = 0;
	int  burst_left = 0;

	initial forever #2 clk = ~clk;

	initial begin
		rx_item.valid = 0;
		rx_item.op = OP_BYTE;
		rx_item.rx_byte = 0;
		tx_item.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_serial_eeprom_loader_protocol: errors");
			$finish;
		end
	end

	function automatic logic [15:0] hex_shift(logic [15:0] a, logic [7:0] b);
		logic [7:0] lc;
		lc = b | 8'h20;
		if (b >= "0" && b <= "9") return {a[11:0], 4'(b - "0")};
		if (lc >= "a" && lc <= "f") return {a[11:0], 4'(lc - "a" + 10)};
		return a;
	endfunction

	function automatic logic [7:0] banner_char(int i);
		string s;
		s = "EEPROM Programmer v2";
		return (i < 20) ? s[i] : sel_pkg::C_SYN;
	endfunction

	task automatic push_tx(logic [7:0] b);
		tx_expected.push_back('{b, 1'b0});
	endtask

	// predict the bytes caused by one accepted item
	task automatic loader_predict(logic op, logic [7:0] b);
		int n0;
		logic [16:0] end_a;
		tx_exp_t t;
		n0 = tx_expected.size();
		end_a = {1'b0, start_a} + {1'b0, len};
		if (op == OP_SLOT) begin
			if (ph == P_RDATA) begin
				push_tx(image[cur[14:0]]);
				cur = cur + 1;
				if ({1'b0, cur} == end_a) begin
					push_tx(sel_pkg::C_ETX); push_tx(sel_pkg::C_EOT); ph = P_SYN;
				end
			end
		end else begin
			case (ph)
				P_SYN: if (b == sel_pkg::C_SYN) begin
					for (int i = 0; i < 21; i++) push_tx(banner_char(i));
					ph = P_SOH;
				end
				P_SOH: if (b == sel_pkg::C_SOH) ph = P_CMD;
				P_CMD: begin
					cmd_b = b; acc = 0; ph = P_START;
				end
				P_START: if (b == sel_pkg::C_US) begin
					start_a = acc; acc = 0; ph = P_LEN;
				end else acc = hex_shift(acc, b);
				P_LEN: if (b == sel_pkg::C_US) begin
					len = acc; acc = 0; ph = P_RST;
				end else acc = acc * 10 + b - 16'h30;
				P_RST: if (b == sel_pkg::C_US) begin
					rvec = acc; acc = 0; ph = P_IRQ;
				end else acc = hex_shift(acc, b);
				P_IRQ: if (b == sel_pkg::C_ETB) begin
					ivec = acc; acc = 0;
					end_a = {1'b0, start_a} + {1'b0, len};
					if (end_a > sel_pkg::MAX_IMAGE_BYTES) begin
						push_tx(sel_pkg::C_NAK); push_tx(sel_pkg::C_EOT); ph = P_SYN;
					end else begin
						push_tx(sel_pkg::C_ACK);
						cur = start_a;
						if (cmd_b == wr_code) begin
							image[15'h7ffc] = rvec[7:0]; image[15'h7ffd] = rvec[15:8];
							image[15'h7ffe] = ivec[7:0]; image[15'h7fff] = ivec[15:8];
							for (int i = 15'h7ffc; i <= 15'h7fff; i++) written[i] = 1;
							ph = P_STX;
						end else if (cmd_b == rd_code) begin
							push_tx(sel_pkg::C_STX);
							if (len == 0) begin
								push_tx(sel_pkg::C_ETX); push_tx(sel_pkg::C_EOT); ph = P_SYN;
							end else ph = P_RDATA;
						end else begin
							push_tx(sel_pkg::C_EOT); ph = P_SYN;
						end
					end
				end else acc = hex_shift(acc, b);
				P_STX: if (b == sel_pkg::C_STX) ph = ({1'b0, cur} == end_a) ? P_ETX : P_WDATA;
				P_WDATA: begin
					image[cur[14:0]] = b; written[cur[14:0]] = 1;
					push_tx(b);
					cur = cur + 1;
					if ({1'b0, cur} == end_a) ph = P_ETX;
				end
				P_ETX: if (b == sel_pkg::C_ETX) begin
					push_tx(sel_pkg::C_EOT); ph = P_SYN;
				end
				default: ;
			endcase
		end
		if (tx_expected.size() > n0) begin
			t = tx_expected.pop_back(); t.last = 1; tx_expected.push_back(t);
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_off && long_stall < 400) begin
			long_stall <= long_stall + 1;
			tx_item.ready <= 0;
		end else if (($urandom_range(0, 99) < 30) && !($urandom_range(0, 7) == 0)) begin
			tx_item.ready <= ($urandom_range(0, 3) != 0);
		end else
			tx_item.ready <= 1;
	end

	// output checker
	always @(posedge clk) begin
		tx_exp_t e;
		if (arst_n && tx_item.valid && tx_item.ready) begin
			if (tx_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte %h last %b", $time, tx_item.tx_byte,
					tx_item.last_of_run);
			end else begin
				e = tx_expected.pop_front();
				if (e.tx !== tx_item.tx_byte || e.last !== tx_item.last_of_run) begin
					errors++;
					$display("%0t: expected %h/%b actual %h/%b", $time, e.tx, e.last,
						tx_item.tx_byte, tx_item.last_of_run);
				end
			end
		end
	end

	// send one item, with bursts and random gaps in between
	task automatic send_item(logic op, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				rx_item.valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		rx_item.valid <= 1;
		rx_item.op <= op;
		rx_item.rx_byte <= b;
		// ready only moves at the rising edge, so sample it mid-cycle
		@(negedge clk);
		while (!rx_item.ready) @(negedge clk);
		@(posedge clk);
		loader_predict(op, b);
	endtask

	task automatic drain();
		rx_item.valid <= 0;
		@(posedge clk);
		while (tx_expected.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_codes(logic [7:0] w, logic [7:0] r);
		drain();
		cfg_we <= 1; cfg_idx <= sel_pkg::CFG_WRITE_CMD; cfg_wdata <= w;
		@(posedge clk);
		cfg_idx <= sel_pkg::CFG_READ_CMD; cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 0;
		wr_code = w; rd_code = r;
	endtask

	task automatic send_hex(logic [15:0] v);
		string s;
		s = $sformatf("%h", v);
		for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
	endtask

	task automatic send_dec(int v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
	endtask

	task automatic send_header(logic [7:0] c, logic [15:0] st, int n, logic [15:0] rv,
			logic [15:0] iv);
		send_item(OP_BYTE, sel_pkg::C_SYN);
		send_item(OP_BYTE, sel_pkg::C_SOH);
		send_item(OP_BYTE, c);
		send_hex(st); send_item(OP_BYTE, sel_pkg::C_US);
		send_dec(n); send_item(OP_BYTE, sel_pkg::C_US);
		send_hex(rv); send_item(OP_BYTE, sel_pkg::C_US);
		send_hex(iv); send_item(OP_BYTE, sel_pkg::C_ETB);
	endtask

	task automatic session_write(logic [15:0] st, int n);
		send_header(wr_code, st, n, 16'($urandom), 16'($urandom));
		send_item(OP_BYTE, sel_pkg::C_STX);
		for (int i = 0; i < n; i++) send_item(OP_BYTE, 8'($urandom));
		send_item(OP_BYTE, 8'h55);
		send_item(OP_BYTE, sel_pkg::C_ETX);
	endtask

	// read only what has been written; one slot item is sent per byte read
	task automatic session_read(logic [15:0] st, int n);
		send_header(rd_code, st, n, 16'h0, 16'h0);
		for (int i = 0; i < n; i++) send_item(OP_SLOT, 8'($urandom));
	endtask

	function automatic bit range_written(logic [15:0] st, int n);
		for (int i = 0; i < n; i++) if (!written[15'(st + i)]) return 0;
		return 1;
	endfunction

	// finish whatever session is open so the next one starts at SYN
	task automatic back_to_idle();
		if (ph == P_RDATA) while (ph == P_RDATA) send_item(OP_SLOT, 8'h0);
		else while (ph != P_SYN) begin
			if (ph == P_STX) send_item(OP_BYTE, sel_pkg::C_STX);
			else if (ph == P_ETX) send_item(OP_BYTE, sel_pkg::C_ETX);
			else if (ph == P_IRQ) send_item(OP_BYTE, sel_pkg::C_ETB);
			else if (ph == P_SOH) send_item(OP_BYTE, sel_pkg::C_SOH);
			else if (ph == P_CMD) send_item(OP_BYTE, 8'hee);
			else send_item(OP_BYTE, sel_pkg::C_US);
		end
	endtask

	task automatic test_directed();
		string junk;
		// extremes of hex fields, upper-case and junk skipped
		junk = "7FfG0";
		send_item(OP_SLOT, 8'hff);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, sel_pkg::C_SYN);
		send_item(OP_BYTE, 8'hff);
		send_item(OP_BYTE, sel_pkg::C_SOH);
		send_item(OP_BYTE, wr_code);
		foreach (junk[i]) send_item(OP_BYTE, junk[i]);
		send_item(OP_BYTE, sel_pkg::C_US);
		send_item(OP_BYTE, "3"); send_item(OP_BYTE, sel_pkg::C_US);
		send_item(OP_BYTE, "x"); send_item(OP_BYTE, sel_pkg::C_US);
		send_item(OP_BYTE, sel_pkg::C_ETB);
		send_item(OP_BYTE, sel_pkg::C_STX);
		send_item(OP_BYTE, 8'h00); send_item(OP_BYTE, 8'hff); send_item(OP_BYTE, 8'ha5);
		send_item(OP_BYTE, sel_pkg::C_ETX);
		drain();
	endtask

	task automatic test_sessions();
		session_write(16'h7ff0, 12);            // reaches the vector page
		session_read(16'h7ff0, 16);
		session_write(16'h0000, 0);             // zero-length write
		session_read(16'h0000, 0);              // zero-length read
		send_header(8'hee, 16'h0, 1, 16'h0, 16'h0);      // unknown command
		send_header(wr_code, 16'h7fff, 2, 16'h0, 16'h0); // rejected header
		send_header(rd_code, 16'hffff, 65535, 16'h0, 16'h0);
		// decimal wrap: 65537 -> 1
		send_header(wr_code, 16'h0010, 65537, 16'h1, 16'h2);
		send_item(OP_BYTE, sel_pkg::C_STX); send_item(OP_BYTE, 8'h3c);
		send_item(OP_BYTE, sel_pkg::C_ETX);
		send_item(OP_BYTE, sel_pkg::C_SYN); send_item(OP_BYTE, sel_pkg::C_SOH);
		send_item(OP_BYTE, rd_code);
		send_item(OP_BYTE, "1"); send_item(OP_BYTE, "0"); send_item(OP_BYTE, sel_pkg::C_US);
		send_item(OP_BYTE, "1"); send_item(OP_BYTE, sel_pkg::C_US);
		send_item(OP_BYTE, sel_pkg::C_US); send_item(OP_BYTE, sel_pkg::C_ETB);
		send_item(OP_BYTE, sel_pkg::C_SYN);                  // ignored while streaming
		send_item(OP_SLOT, 8'h00);
		drain();
	endtask

	task automatic test_random(int budget);
		int sent, n, k;
		logic [15:0] st;
		logic [7:0] c;
		sent = 0;
		while (sent < budget) begin
			back_to_idle();
			k = $urandom_range(0, 9);
			n = $urandom_range(0, 8);
			st = 16'($urandom_range(0, 32767 - 8));
			if (k < 5) session_write(st, n);
			else if (k < 8) begin
				st = 16'h7ff8;
				if (range_written(st, n)) session_read(st, n);
				else session_write(st, n);
			end else if (k == 8) begin
				// keep random headers away from real commands
				c = 8'($urandom);
				while (c == wr_code || c == rd_code) c = c + 8'd1;
				send_header(c, 16'($urandom), $urandom_range(0, 65535),
					16'($urandom), 16'($urandom));
			end else begin
				send_item(OP_BYTE, 8'($urandom));
				send_item(OP_SLOT, 8'($urandom));
			end
			sent += 20 + n;
			back_to_idle();
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_off = 1;
		session_write(16'h0100, 8);
		session_write(16'h0200, 8);
		wait (long_stall >= 400);
		hold_off = 0;
		drain();
	endtask

	initial begin
		wr_code = 1; rd_code = 2;
		ph = P_SYN; cmd_b = 0; acc = 0; start_a = 0; len = 0;
		rvec = 0; ivec = 0; cur = 0;
		for (int i = 0; i < 32768; i++) begin
			image[i] = 0; written[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_sessions();
		test_backpressure();
		set_codes(8'hff, 8'h00);
		test_random(30);
		set_codes(8'h07, 8'h07);               // equal codes: write wins
		test_random(20);
		set_codes(8'h01, 8'h02);
		test_random(20);
		drain();
		if (errors == 0) $display("tb_serial_eeprom_loader_protocol: clean");
		else $display("tb_serial_eeprom_loader_protocol: errors");
		$finish;
	end
endmodule
